[rtl/core/eop_pkg.sv]
package eop_pkg;

	// Datapath widths
	localparam int ZW = 34;          // angle, Q3.30 radians, signed
	localparam int XW = 33;          // sine/cosine, Q30, signed
	localparam int VW = 58;          // atan2 operands, Q38, signed
	localparam int LEN_W = 23;       // axis lengths, unsigned Q15.8
	localparam int COORD_W = 24;     // coordinates, signed Q15.8
	localparam int HEAD_W = 16;      // heading, signed Q8.7
	localparam int ATAN_ENTRIES = 24;

	// Angle constants
	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518737;
	localparam logic [31:0] PI_Q30 = 32'd3373259369;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629684;
	localparam logic [34:0] TWO_PI_DIV = 35'd6746518738;
	localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;

	// Degree scaling: half a turn in Q8.7 and floor(2^48 / PI_Q30)
	localparam logic [14:0] DEG_HALF_TURN = 15'd23040;
	localparam logic [16:0] RECIP_PI = 17'd83443;

	// Register indexes
	localparam logic [1:0] REG_A_LENGTH = 2'd0;
	localparam logic [1:0] REG_C_LENGTH = 2'd1;
	localparam logic [1:0] REG_CENTER_X = 2'd2;
	localparam logic [1:0] REG_CENTER_Y = 2'd3;

	// Ellipse geometry handed from the register block to the datapath
	typedef struct packed {
		logic [LEN_W-1:0]          a;
		logic [LEN_W-1:0]          b;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} geom_t;

	// arctan(2^-i) in Q30
	function automatic logic [29:0] atan_val(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// Clamp a widened coordinate to the signed 24-bit range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [27:0] v);
		if (v > 28'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -28'sd8388608)
			return 24'sh800000;
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

[rtl/core/eop_axis.sv]
module eop_axis (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [eop_pkg::COORD_W-1:0] wr_data,
	output eop_pkg::geom_t             geom,
	output logic                       ready
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SQUARE = 2'd1;
	localparam logic [1:0] ST_ROOT   = 2'd2;

	logic [1:0]                         state_q;
	logic [eop_pkg::LEN_W-1:0]          a_q, c_q, b_q;
	logic signed [eop_pkg::COORD_W-1:0] cx_q, cy_q;
	logic [46:0]                        rad_q, res_q, bit_q;
	logic [47:0]                        trial;
	logic                               take;
	logic [46:0]                        res_next;

	// One step of the bit-serial square root
	assign trial    = {1'b0, res_q} + {1'b0, bit_q};
	assign take     = {1'b0, rad_q} >= trial;
	assign res_next = take ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// Hold the registers; recompute the minor axis after a write to a or c
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q     <= '0;
			c_q     <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			b_q     <= '0;
		end else begin
			unique case (state_q)
				ST_SQUARE: begin
					if (c_q >= a_q) begin
						b_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (bit_q[0]) begin
						b_q     <= res_next[eop_pkg::LEN_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: ;
			endcase
			if (wr_en) begin
				unique case (wr_index)
					eop_pkg::REG_A_LENGTH: begin
						a_q     <= wr_data[eop_pkg::LEN_W-1:0];
						state_q <= ST_SQUARE;
					end
					eop_pkg::REG_C_LENGTH: begin
						c_q     <= wr_data[eop_pkg::LEN_W-1:0];
						state_q <= ST_SQUARE;
					end
					eop_pkg::REG_CENTER_X: cx_q <= wr_data;
					eop_pkg::REG_CENTER_Y: cy_q <= wr_data;
				endcase
			end
		end
	end

	// Square-root working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SQUARE) begin
			rad_q <= {1'b0, (46'(a_q) * 46'(a_q)) - (46'(c_q) * 46'(c_q))};
			res_q <= '0;
			bit_q <= 47'd1 << 46;
		end else if (state_q == ST_ROOT) begin
			if (take)
				rad_q <= rad_q - trial[46:0];
			res_q <= res_next;
			bit_q <= bit_q >> 2;
		end
	end

	assign geom.a  = a_q;
	assign geom.b  = b_q;
	assign geom.cx = cx_q;
	assign geom.cy = cy_q;
	assign ready   = (state_q == ST_IDLE);

endmodule

[rtl/core/eop_sincos.sv]
module eop_sincos #(
	parameter int STEPS = 16,
	parameter int PHASE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_v,
	input  logic [PHASE_BITS-1:0]         phase,
	output logic                          out_v,
	output logic [1:0]                    quad,
	output logic signed [eop_pkg::XW-1:0] cos_val,
	output logic signed [eop_pkg::XW-1:0] sin_val
);

	logic [PHASE_BITS+30:0]        prod;
	logic                          v_s [STEPS+1];
	logic [1:0]                    q_s [STEPS+1];
	logic signed [eop_pkg::XW-1:0] x_s [STEPS+1];
	logic signed [eop_pkg::XW-1:0] y_s [STEPS+1];
	logic signed [eop_pkg::ZW-1:0] z_s [STEPS+1];

	// Residual angle within the quadrant
	assign prod = (PHASE_BITS+31)'(phase[PHASE_BITS-3:0]) * (PHASE_BITS+31)'(eop_pkg::TWO_PI_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= phase[PHASE_BITS-1:PHASE_BITS-2];
			x_s[0] <= eop_pkg::GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= {3'b000, prod[PHASE_BITS+30:PHASE_BITS]};
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [eop_pkg::XW-1:0] dx, dy;
		logic signed [eop_pkg::ZW-1:0] da;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = $signed({{(eop_pkg::ZW-30){1'b0}}, eop_pkg::atan_val(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][eop_pkg::ZW-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - da;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + da;
				end
			end
		end
	end

	assign out_v   = v_s[STEPS];
	assign quad    = q_s[STEPS];
	assign cos_val = x_s[STEPS];
	assign sin_val = y_s[STEPS];

endmodule

[rtl/core/eop_place.sv]
module eop_place (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  eop_pkg::geom_t                     geom,
	input  logic                               in_v,
	input  logic [1:0]                         quad,
	input  logic signed [eop_pkg::XW-1:0]      cos_val,
	input  logic signed [eop_pkg::XW-1:0]      sin_val,
	output logic                               out_v,
	output logic signed [eop_pkg::COORD_W-1:0] px,
	output logic signed [eop_pkg::COORD_W-1:0] py,
	output logic signed [eop_pkg::VW-1:0]      vx,
	output logic signed [eop_pkg::VW-1:0]      vy
);

	logic signed [eop_pkg::XW-1:0]      cw, sw;
	logic                               v_s1, v_s2;
	logic signed [56:0]                 ax_s1, by_s1;
	logic signed [56:0]                 axr, byr;
	logic signed [27:0]                 sx, sy;
	logic signed [eop_pkg::COORD_W-1:0] px_s2, py_s2;
	logic signed [eop_pkg::VW-1:0]      vx_s2, vy_s2;

	// Fold the quadrant back in
	always_comb begin
		unique case (quad)
			2'd0: begin cw = cos_val;  sw = sin_val;  end
			2'd1: begin cw = -sin_val; sw = cos_val;  end
			2'd2: begin cw = -cos_val; sw = -sin_val; end
			default: begin cw = sin_val; sw = -cos_val; end
		endcase
	end

	// Round the products to Q8 and offset by the center
	assign axr = ax_s1 + 57'sd536870912;
	assign byr = by_s1 + 57'sd536870912;
	assign sx  = $signed({{4{geom.cx[23]}}, geom.cx}) - $signed({axr[56], axr[56:30]});
	assign sy  = $signed({{4{geom.cy[23]}}, geom.cy}) + $signed({byr[56], byr[56:30]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= $signed({1'b0, geom.a}) * cw;
			by_s1 <= $signed({1'b0, geom.b}) * sw;
			px_s2 <= eop_pkg::sat_coord(sx);
			py_s2 <= eop_pkg::sat_coord(sy);
			vx_s2 <= $signed({5'b00000, geom.a, 30'b0}) - $signed({ax_s1[56], ax_s1});
			vy_s2 <= $signed({by_s1[56], by_s1});
		end
	end

	assign out_v = v_s2;
	assign px    = px_s2;
	assign py    = py_s2;
	assign vx    = vx_s2;
	assign vy    = vy_s2;

endmodule

[rtl/core/eop_atan2.sv]
module eop_atan2 #(
	parameter int STEPS = 16,
	parameter int TAG_W = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_v,
	input  logic signed [eop_pkg::VW-1:0] vx,
	input  logic signed [eop_pkg::VW-1:0] vy,
	input  logic [TAG_W-1:0]              in_tag,
	output logic                          out_v,
	output logic signed [eop_pkg::ZW-1:0] ang,
	output logic [TAG_W-1:0]              out_tag
);

	logic                          v_s  [STEPS+1];
	logic                          nz_s [STEPS+1];
	logic [TAG_W-1:0]              t_s  [STEPS+1];
	logic signed [eop_pkg::VW-1:0] x_s  [STEPS+1];
	logic signed [eop_pkg::VW-1:0] y_s  [STEPS+1];
	logic signed [eop_pkg::ZW-1:0] z_s  [STEPS+1];
	logic signed [eop_pkg::ZW-1:0] half_pi;

	assign half_pi = $signed({2'b00, eop_pkg::HALF_PI_Q30});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_v;
	end

	// Rotate a vector with negative x by a quarter turn first
	always_ff @(posedge clk) begin
		if (en) begin
			t_s[0]  <= in_tag;
			nz_s[0] <= (vx != '0) || (vy != '0);
			if (vx[eop_pkg::VW-1]) begin
				if (!vy[eop_pkg::VW-1]) begin
					x_s[0] <= vy;
					y_s[0] <= -vx;
					z_s[0] <= half_pi;
				end else begin
					x_s[0] <= -vy;
					y_s[0] <= vx;
					z_s[0] <= -half_pi;
				end
			end else begin
				x_s[0] <= vx;
				y_s[0] <= vy;
				z_s[0] <= '0;
			end
		end
	end

	// One vectoring step per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		logic signed [eop_pkg::VW-1:0] dx, dy;
		logic signed [eop_pkg::ZW-1:0] da;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = $signed({{(eop_pkg::ZW-30){1'b0}}, eop_pkg::atan_val(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s[i+1]  <= t_s[i];
				nz_s[i+1] <= nz_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + da;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - da;
				end
			end
		end
	end

	// A zero vector has angle zero
	assign out_v   = v_s[STEPS];
	assign ang     = nz_s[STEPS] ? z_s[STEPS] : '0;
	assign out_tag = t_s[STEPS];

endmodule

[rtl/core/eop_deg.sv]
module eop_deg #(
	parameter int TAG_W = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_v,
	input  logic signed [eop_pkg::ZW-1:0]     ang,
	input  logic [TAG_W-1:0]                  in_tag,
	output logic                              out_v,
	output logic signed [eop_pkg::HEAD_W-1:0] heading,
	output logic [TAG_W-1:0]                  out_tag
);

	logic [32:0]                       mag;
	logic                              v_d1, v_d2, v_d3, v_d4;
	logic                              neg_d1, neg_d2, neg_d3;
	logic [TAG_W-1:0]                  t_d1, t_d2, t_d3, t_d4;
	logic [47:0]                       n_d1, n_d2;
	logic [48:0]                       est_prod, rem_full;
	logic [16:0]                       est_d2, est_d3;
	logic [34:0]                       rem_d3;
	logic [16:0]                       q;
	logic [14:0]                       qc;
	logic signed [eop_pkg::HEAD_W-1:0] hd_d4;

	assign mag = ang[eop_pkg::ZW-1] ? 33'(-ang) : ang[32:0];

	// Quotient estimate by reciprocal, then remainder for the correction
	assign est_prod = 49'(n_d1[47:16]) * 49'(eop_pkg::RECIP_PI);
	assign rem_full = 49'(n_d2) - 49'(est_d2) * 49'(eop_pkg::PI_Q30);

	// Correct the estimate by up to two and clamp to half a turn
	always_comb begin
		q  = est_d3 + 17'(rem_d3 >= 35'(eop_pkg::PI_Q30)) + 17'(rem_d3 >= eop_pkg::TWO_PI_DIV);
		qc = (q > 17'(eop_pkg::DEG_HALF_TURN)) ? eop_pkg::DEG_HALF_TURN : q[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			v_d3 <= 1'b0;
			v_d4 <= 1'b0;
		end else if (en) begin
			v_d1 <= in_v;
			v_d2 <= v_d1;
			v_d3 <= v_d2;
			v_d4 <= v_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_d1   <= in_tag;
			neg_d1 <= (ang > 0);
			n_d1   <= 48'(mag) * 48'(eop_pkg::DEG_HALF_TURN) + 48'(eop_pkg::HALF_PI_Q30);
			t_d2   <= t_d1;
			neg_d2 <= neg_d1;
			n_d2   <= n_d1;
			est_d2 <= est_prod[48:32];
			t_d3   <= t_d2;
			neg_d3 <= neg_d2;
			est_d3 <= est_d2;
			rem_d3 <= rem_full[34:0];
			t_d4   <= t_d3;
			hd_d4  <= neg_d3 ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
		end
	end

	assign out_v   = v_d4;
	assign heading = hd_d4;
	assign out_tag = t_d4;

endmodule

[rtl/core/ellipse_orbit_point_core.sv]
// Point on an ellipse with heading, one phase in and one point out per transfer.
// Input channel: in_valid/in_ready with phase, the low PHASE_BITS bits being
// the fraction of a revolution. Output channel: out_valid/out_ready with
// pos_x, pos_y (signed Q15.8, saturated) and heading_deg (signed Q8.7).
// Registers a_length, c_length, center_x, center_y are for the user to write through
// cfg_wr_en/cfg_wr_index/cfg_wr_data while the block holds no item; it does not enforce this.
// Throughput: one item per cycle unless the receiver stalls or the minor axis
// is being recomputed.
// A write to a_length or c_length starts a bit-serial square root for the
// minor axis; in_ready stays low while it runs, or for one cycle when c_length
// is not below a_length.
// Reset clears the configuration registers to zero and empties the pipeline;
// the minor axis is zero after reset, and the block is ready at once.
// When the receiver holds out_ready low with a result pending, the whole
// pipeline stalls in place and in_ready drops; nothing is lost or repeated.
module ellipse_orbit_point_core #(
	parameter int CORDIC_STEPS = 16,
	parameter int PHASE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [1:0]                         cfg_wr_index,
	input  logic [eop_pkg::COORD_W-1:0]        cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [PHASE_BITS-1:0]              phase,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [eop_pkg::COORD_W-1:0] pos_x,
	output logic signed [eop_pkg::COORD_W-1:0] pos_y,
	output logic signed [eop_pkg::HEAD_W-1:0]  heading_deg
);

	localparam int TAG_W = 2 * eop_pkg::COORD_W;

	eop_pkg::geom_t                geom;
	logic                          geom_ready;
	logic                          en, accept;
	logic                          sc_v, pl_v, at_v;
	logic [1:0]                    quad;
	logic signed [eop_pkg::XW-1:0] cos_val, sin_val;
	logic signed [eop_pkg::COORD_W-1:0] px, py;
	logic signed [eop_pkg::VW-1:0] vx, vy;
	logic signed [eop_pkg::ZW-1:0] ang;
	logic [TAG_W-1:0]              at_tag, out_tag;

	// Advance the pipeline unless a result waits on the receiver
	assign en       = !out_valid || out_ready;
	assign in_ready = en && geom_ready;
	assign accept   = in_valid && in_ready;

	eop_axis u_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_wr_index),
		.wr_data  (cfg_wr_data),
		.geom     (geom),
		.ready    (geom_ready)
	);

	eop_sincos #(
		.STEPS      (CORDIC_STEPS),
		.PHASE_BITS (PHASE_BITS)
	) u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (accept),
		.phase   (phase),
		.out_v   (sc_v),
		.quad    (quad),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	eop_place u_place (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.geom    (geom),
		.in_v    (sc_v),
		.quad    (quad),
		.cos_val (cos_val),
		.sin_val (sin_val),
		.out_v   (pl_v),
		.px      (px),
		.py      (py),
		.vx      (vx),
		.vy      (vy)
	);

	eop_atan2 #(
		.STEPS (CORDIC_STEPS),
		.TAG_W (TAG_W)
	) u_atan2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (pl_v),
		.vx      (vx),
		.vy      (vy),
		.in_tag  ({px, py}),
		.out_v   (at_v),
		.ang     (ang),
		.out_tag (at_tag)
	);

	eop_deg #(
		.TAG_W (TAG_W)
	) u_deg (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (at_v),
		.ang     (ang),
		.in_tag  (at_tag),
		.out_v   (out_valid),
		.heading (heading_deg),
		.out_tag (out_tag)
	);

	assign pos_x = out_tag[TAG_W-1:eop_pkg::COORD_W];
	assign pos_y = out_tag[eop_pkg::COORD_W-1:0];

	// No transfer is taken while the minor axis is being recomputed
	a_ready_needs_axis: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> geom_ready)
		else $error("input taken during minor axis update");

	// A write to an axis length blocks input on the next cycle
	a_axis_write_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && (cfg_wr_index == eop_pkg::REG_A_LENGTH ||
			cfg_wr_index == eop_pkg::REG_C_LENGTH) |=> !in_ready)
		else $error("input open right after axis write");

	// Heading never leaves half a turn
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(heading_deg) <= 16'sd23040 &&
			$signed(heading_deg) >= -16'sd23040))
		else $error("heading out of range");

endmodule

[tb/ellipse_orbit_point_core_tb.sv]
module ellipse_orbit_point_core_tb;

	localparam int STEPS = 16;
	localparam int PBITS = 16;
	localparam int LATENCY = 2 * STEPS + 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int COORD_W = eop_pkg::COORD_W;
	localparam int HEAD_W = eop_pkg::HEAD_W;
	localparam int LEN_W = eop_pkg::LEN_W;
	localparam longint PI_Q = 64'd3373259369;
	localparam longint HALF_PI_Q = 64'd1686629684;
	localparam longint TWO_PI_Q = 64'd6746518737;
	localparam longint GAIN_Q = 64'd652032874;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [HEAD_W-1:0]  hd;
	} point_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_wr_index;
	logic [COORD_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic [PBITS-1:0] phase;
	logic out_valid;
	logic out_ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [HEAD_W-1:0] heading_deg;

	// shadow of the configuration registers
	logic [LEN_W-1:0] axis_a, focal_c;
	logic signed [COORD_W-1:0] ctr_x, ctr_y;

	point_t pending_points[$];
	int errors;
	int quiet_cycles;
	bit no_idle;
	longint arctab[24];

	ellipse_orbit_point_core #(.CORDIC_STEPS(STEPS), .PHASE_BITS(PBITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .phase(phase),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x(pos_x), .pos_y(pos_y), .heading_deg(heading_deg)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp24(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	function automatic longint minor_axis(longint a, longint c);
		longint d, res, bit_v;
		if (c >= a)
			return 0;
		d = a * a - c * c;
		res = 0;
		bit_v = 64'd1 << 46;
		while (bit_v > d)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (d >= res + bit_v) begin
				d = d - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, t, dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI_Q;
			end else begin
				x = -y; y = t; z = -HALF_PI_Q;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += arctab[i];
			end else begin
				x -= dx; y += dy; z -= arctab[i];
			end
		end
		return z;
	endfunction

	// compute the expected point and heading for one phase
	function automatic point_t orbit_point(logic [PBITS-1:0] ph);
		point_t p;
		logic [1:0] quad;
		longint r, z, cx0, sy0, dx, dy, cw, sw, a, b, ax, by, ang, mag, q, hd;
		quad = ph[PBITS-1 -: 2];
		r = longint'(ph[PBITS-3:0]);
		z = (r * TWO_PI_Q) >>> PBITS;
		cx0 = GAIN_Q;
		sy0 = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = shr(sy0, i);
			dy = shr(cx0, i);
			if (z >= 0) begin
				cx0 -= dx; sy0 += dy; z -= arctab[i];
			end else begin
				cx0 += dx; sy0 -= dy; z += arctab[i];
			end
		end
		case (quad)
			2'd0: begin cw = cx0; sw = sy0; end
			2'd1: begin cw = -sy0; sw = cx0; end
			2'd2: begin cw = -cx0; sw = -sy0; end
			default: begin cw = sy0; sw = -cx0; end
		endcase
		a = longint'(axis_a);
		b = minor_axis(longint'(axis_a), longint'(focal_c));
		ax = a * cw;
		by = b * sw;
		p.x = COORD_W'(clamp24(longint'(ctr_x) - shr(ax + (64'sd1 <<< 29), 30)));
		p.y = COORD_W'(clamp24(longint'(ctr_y) + shr(by + (64'sd1 <<< 29), 30)));
		ang = vector_angle(by, a * (64'sd1 <<< 30) - ax);
		mag = ang < 0 ? -ang : ang;
		q = (mag * 23040 + PI_Q / 2) / PI_Q;
		if (q > 23040)
			q = 23040;
		hd = ang > 0 ? -q : q;
		p.hd = HEAD_W'(hd);
		return p;
	endfunction

	// check each output transfer against the oldest prediction
	always @(posedge clk) begin
		point_t e;
		if (out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected result x=%0d y=%0d hd=%0d", pos_x, pos_y, heading_deg);
				errors++;
			end else begin
				e = pending_points.pop_front();
				if (pos_x !== e.x) begin
					$error("pos_x expected %0d actual %0d", e.x, pos_x);
					errors++;
				end
				if (pos_y !== e.y) begin
					$error("pos_y expected %0d actual %0d", e.y, pos_y);
					errors++;
				end
				if (heading_deg !== e.hd) begin
					$error("heading_deg expected %0d actual %0d", e.hd, heading_deg);
					errors++;
				end
			end
		end
	end

	// randomly stall the receiver
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 35);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ellipse_orbit_point_core_tb failed");
			$finish;
		end
	end

	// offer one phase; valid stays up until the next item or an idle cycle drops it
	task automatic send_phase(logic [PBITS-1:0] ph);
		if (!no_idle)
			while ($urandom_range(99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		phase <= ph;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_points.push_back(orbit_point(ph));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// write one register while the block holds nothing
	task automatic write_reg(logic [1:0] idx, logic [COORD_W-1:0] val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			eop_pkg::REG_A_LENGTH: axis_a = val[LEN_W-1:0];
			eop_pkg::REG_C_LENGTH: focal_c = val[LEN_W-1:0];
			eop_pkg::REG_CENTER_X: ctr_x = val;
			default: ctr_y = val;
		endcase
	endtask

	task automatic set_geometry(logic [LEN_W-1:0] a, logic [LEN_W-1:0] c,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		write_reg(eop_pkg::REG_A_LENGTH, {1'b0, a});
		write_reg(eop_pkg::REG_C_LENGTH, {1'b0, c});
		write_reg(eop_pkg::REG_CENTER_X, x);
		write_reg(eop_pkg::REG_CENTER_Y, y);
	endtask

	task automatic test_reset_defaults;
		send_phase(16'h0000);
		send_phase(16'h4000);
		send_phase(16'hFFFF);
	endtask

	task automatic test_directed_phases;
		logic [PBITS-1:0] phs[8] = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000,
			16'h8000, 16'hC000, 16'hFFFF, 16'h2AAA};
		set_geometry(23'd25600, 23'd15360, 24'd0, 24'd0);
		foreach (phs[i])
			send_phase(phs[i]);
	endtask

	task automatic test_special_cases;
		// focal distance at and beyond the axis: minor axis collapses
		set_geometry(23'd5000, 23'd5000, 24'd100, -24'sd100);
		send_phase(16'h4000);
		send_phase(16'h1234);
		write_reg(eop_pkg::REG_C_LENGTH, 24'h7FFFFF);
		send_phase(16'h0000);
		// zero axis gives both atan2 operands zero
		write_reg(eop_pkg::REG_A_LENGTH, 24'd0);
		send_phase(16'h6000);
		// largest axis with extreme centers saturates coordinates
		set_geometry(23'h7FFFFF, 23'd0, 24'h7FFFFF, 24'h800000);
		send_phase(16'h0000);
		send_phase(16'h8000);
		send_phase(16'h4000);
		send_phase(16'hC000);
		set_geometry(23'h7FFFFF, 23'h7FFFFE, 24'h800000, 24'h7FFFFF);
		send_phase(16'h8000);
		send_phase(16'h5555);
		// center x at minus one LSB: all ones
		write_reg(eop_pkg::REG_CENTER_X, 24'hFFFFFF);
		send_phase(16'hAAAA);
	endtask

	task automatic random_block(int n);
		for (int i = 0; i < n; i++)
			send_phase(PBITS'($urandom));
	endtask

	task automatic test_random_geometry;
		for (int g = 0; g < 8; g++) begin
			set_geometry(LEN_W'($urandom_range(g < 4 ? 32'h7FFF : 32'h7FFFFF)),
				LEN_W'($urandom_range(g < 4 ? 32'h7FFF : 32'h7FFFFF)),
				COORD_W'($urandom), COORD_W'($urandom));
			random_block(40);
		end
		// steady stretch with no idling on either side
		no_idle = 1'b1;
		random_block(60);
		no_idle = 1'b0;
		// hold off until every result is back, then continue
		drain();
		set_geometry(23'd1000, 23'd0, 24'd0, 24'd0);
		random_block(50);
	endtask

	initial begin
		arctab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
			65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
		errors = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		axis_a = '0;
		focal_c = '0;
		ctr_x = '0;
		ctr_y = '0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_index = eop_pkg::REG_A_LENGTH;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		phase = '0;
		out_ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_phases();
		test_special_cases();
		test_random_geometry();
		drain();
		if (errors == 0)
			$display("ellipse_orbit_point_core_tb passed");
		else
			$display("ellipse_orbit_point_core_tb failed");
		$finish;
	end

endmodule
